>>> hdl/imu_ssn_pkg.sv
// ----------------------------------------------------------------------------
// IMU sample scale/normalize package
// Shared types, constants and step functions for the IMU scaling block.
// ----------------------------------------------------------------------------
package imu_ssn_pkg;

    localparam logic [30:0] RATE_K0 = 31'd119938113;
    localparam logic [30:0] RATE_K1 = 31'd479752452;
    localparam logic [30:0] RATE_K2 = 31'd1919009807;

    localparam logic [15:0] ACCEL_MIN_RESET = 16'd2676;

    localparam logic REG_GYRO_RANGE = 1'b0;
    localparam logic REG_ACCEL_MIN  = 1'b1;

    localparam logic [1:0] RANGE_V0 = 2'd0;
    localparam logic [1:0] RANGE_V1 = 2'd1;

    typedef struct packed {
        logic [2:0][31:0] rate;
        logic [2:0][31:0] accel;
        logic [63:0]      sum_sq;
        logic             below;
    } t_item;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [33:0] rem;
        logic        qbit;
    } t_div;

    function automatic logic [30:0] rate_factor(input logic [1:0] range);
        logic [30:0] k;
        unique case (range)
            RANGE_V0: k = RATE_K0;
            RANGE_V1: k = RATE_K1;
            default:  k = RATE_K2;
        endcase
        return k;
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt cur, input logic [1:0] bits);
        t_sqrt       nxt;
        logic [34:0] rem;
        logic [34:0] trial;
        rem   = {cur.rem[32:0], bits};
        trial = {1'b0, cur.root, 2'b01};
        if (rem >= trial) begin
            nxt.rem  = rem - trial;
            nxt.root = {cur.root[30:0], 1'b1};
        end else begin
            nxt.rem  = rem;
            nxt.root = {cur.root[30:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic t_div div_step(input logic [33:0] rem_in, input logic [32:0] den,
                                      input logic nbit);
        t_div        nxt;
        logic [33:0] rem;
        rem = {rem_in[32:0], nbit};
        if (rem >= {1'b0, den}) begin
            nxt.rem  = rem - {1'b0, den};
            nxt.qbit = 1'b1;
        end else begin
            nxt.rem  = rem;
            nxt.qbit = 1'b0;
        end
        return nxt;
    endfunction

endpackage

>>> hdl/imu_ssn_front.sv
// ----------------------------------------------------------------------------
// IMU front end
// Accepts samples, scales gyro axes, squares accel axes and classifies
// the magnitude against the threshold.
// ----------------------------------------------------------------------------
module imu_ssn_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [191:0]         i_data,
    output logic                 o_push,
    input  logic                 i_push_ready,
    output imu_ssn_pkg::t_item   o_item
);
    import imu_ssn_pkg::*;

    logic [1:0]        r_gyro_range;
    logic [15:0]       r_accel_min;

    logic              r_s1_valid;
    logic [2:0][31:0]  r_graw;
    logic [2:0][31:0]  r_araw;
    logic [1:0]        r_s1_range;
    logic [15:0]       r_s1_thr;

    logic              r_s2_valid;
    logic [2:0][63:0]  r_gprod;
    logic [2:0][63:0]  r_asq;
    logic [2:0][31:0]  r_s2_araw;
    logic [31:0]       r_thr2;

    logic              s1_ready;
    logic              s2_ready;
    logic [2:0][31:0]  mag;
    logic [30:0]       k;
    logic [2:0][63:0]  rsum;
    logic [63:0]       sum_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_range <= 2'd0;
            r_accel_min  <= ACCEL_MIN_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_GYRO_RANGE: r_gyro_range <= i_cfg_data[1:0];
                REG_ACCEL_MIN:  r_accel_min  <= i_cfg_data;
                default:        r_accel_min  <= r_accel_min;
            endcase
        end
    end

    assign s2_ready = !r_s2_valid || i_push_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_push   = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= i_valid;
            if (s2_ready) r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_graw[i] <= i_data[32*i +: 32];
                r_araw[i] <= i_data[96 + 32*i +: 32];
            end
            r_s1_range <= r_gyro_range;
            r_s1_thr   <= r_accel_min;
        end
    end

    assign k = rate_factor(r_s1_range);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_araw[i][31] ? (~r_araw[i] + 32'd1) : r_araw[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_gprod[i]   <= 64'($signed(r_graw[i]) * $signed({1'b0, k}));
                r_asq[i]     <= 64'(mag[i]) * 64'(mag[i]);
                r_s2_araw[i] <= r_araw[i];
            end
            r_thr2 <= 32'(r_s1_thr) * 32'(r_s1_thr);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum[i] = r_gprod[i] + 64'h0000_0000_8000_0000;
        end
        sum_sq = r_asq[0] + r_asq[1] + r_asq[2];
        for (int i = 0; i < 3; i++) begin
            o_item.rate[i]  = rsum[i][63:32];
            o_item.accel[i] = r_s2_araw[i];
        end
        o_item.sum_sq = sum_sq;
        o_item.below  = (sum_sq <= {32'd0, r_thr2});
    end

endmodule

>>> hdl/imu_ssn_queue.sv
// ----------------------------------------------------------------------------
// IMU item queue
// Short FIFO between the front end and the normalizing back end.
// ----------------------------------------------------------------------------
module imu_ssn_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_push_ready,
    input  imu_ssn_pkg::t_item   i_item,
    output logic                 o_valid,
    input  logic                 i_pop,
    output imu_ssn_pkg::t_item   o_item
);
    import imu_ssn_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_item       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

>>> hdl/imu_ssn_back.sv
// ----------------------------------------------------------------------------
// IMU back end
// Normalizes the accel sum of squares, takes its square root and divides
// each axis by the magnitude, two bits per cycle.
// ----------------------------------------------------------------------------
module imu_ssn_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  imu_ssn_pkg::t_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [191:0]         o_data,
    output logic                 o_below
);
    import imu_ssn_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]        r_state;
    logic [63:0]       r_v;
    logic [4:0]        r_e;
    logic [3:0]        r_cnt;
    t_sqrt             r_sq;
    logic [32:0]       r_den;
    logic [2:0][31:0]  r_mag;
    logic [2:0]        r_neg;
    logic [2:0][31:0]  r_rate;
    logic              r_below;
    logic [2:0][31:0]  r_nlow;
    logic [2:0][33:0]  r_drem;
    logic [2:0][31:0]  r_q;
    logic              r_out_valid;
    logic [191:0]      r_out_data;
    logic              r_out_below;

    t_sqrt             sq_a;
    t_sqrt             sq_b;
    t_div              dv_a [3];
    t_div              dv_b [3];
    logic [2:0][63:0]  num;
    logic [5:0]        shamt;
    logic              out_load;
    logic [2:0][31:0]  unit;

    assign o_pop    = (r_state == ST_IDLE) && i_valid;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_below  = r_out_below;

    assign sq_a  = sqrt_step(r_sq, r_v[63:62]);
    assign sq_b  = sqrt_step(sq_a, r_v[61:60]);
    assign shamt = 6'd31 + {1'b0, r_e};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i]  = ({32'd0, r_mag[i]} << shamt) + {32'd0, r_sq.root};
            dv_a[i] = div_step(r_drem[i], r_den, r_nlow[i][31]);
            dv_b[i] = div_step(dv_a[i].rem, r_den, r_nlow[i][30]);
            unit[i] = r_below ? 32'd0 : (r_neg[i] ? (~r_q[i] + 32'd1) : r_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_valid) r_state <= i_item.below ? ST_FIN : ST_NORM;
                ST_NORM: begin
                    if (r_v[63:62] != 2'd0) begin
                        r_state <= ST_SQRT;
                        r_cnt   <= 4'd0;
                    end
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_state <= ST_DIV;
                    r_cnt   <= 4'd0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_state <= ST_FIN;
                end
                ST_FIN:  if (out_load) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_rate[i] <= i_item.rate[i];
                    r_neg[i]  <= i_item.accel[i][31];
                    r_mag[i]  <= i_item.accel[i][31] ? (~i_item.accel[i] + 32'd1)
                                                     : i_item.accel[i];
                end
                r_v     <= i_item.sum_sq;
                r_e     <= 5'd0;
                r_below <= i_item.below;
                r_sq    <= '0;
            end
            ST_NORM: begin
                if (r_v[63:56] == 8'd0) begin
                    r_v <= {r_v[55:0], 8'd0};
                    r_e <= r_e + 5'd4;
                end else if (r_v[63:62] == 2'd0) begin
                    r_v <= {r_v[61:0], 2'd0};
                    r_e <= r_e + 5'd1;
                end
            end
            ST_SQRT: begin
                r_sq <= sq_b;
                r_v  <= {r_v[59:0], 4'd0};
            end
            ST_PREP: begin
                r_den <= {r_sq.root, 1'b0};
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= {2'b00, num[i][63:32]};
                    r_nlow[i] <= num[i][31:0];
                    r_q[i]    <= 32'd0;
                end
            end
            ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= dv_b[i].rem;
                    r_nlow[i] <= {r_nlow[i][29:0], 2'b00};
                    r_q[i]    <= {r_q[i][29:0], dv_a[i].qbit, dv_b[i].qbit};
                end
            end
            default: r_v <= r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data  <= {unit[2], unit[1], unit[0], r_rate[2], r_rate[1], r_rate[0]};
            r_out_below <= r_below;
        end
    end

    a_root_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |-> r_sq.root[31])
        else $error("square root not normalized");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_drem[0] < {1'b0, r_den}) && (r_drem[1] < {1'b0, r_den})
                                && (r_drem[2] < {1'b0, r_den}))
        else $error("divider remainder out of range");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !r_below) |-> (r_q[0] <= 32'h4000_0000)
            && (r_q[1] <= 32'h4000_0000) && (r_q[2] <= 32'h4000_0000))
        else $error("unit component exceeds one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && !i_ready) |=> (r_state == ST_FIN))
        else $error("result lost under stall");

endmodule

>>> hdl/imu_sample_scale_normalize.sv
// ----------------------------------------------------------------------------
// IMU sample scale and normalize
// Gyro axes to rad/s (Q8.24) and accel vector to a unit vector (Q2.30).
// ----------------------------------------------------------------------------
// Input stream: one beat per sample, twelve 16-bit half words in tdata.
// Output stream: one beat per sample, three rates and three unit components
// in tdata, the below-threshold flag in tuser.
// Config: i_cfg_wen writes i_cfg_data into register i_cfg_idx
// (0 = gyro range, 1 = accel minimum magnitude); write only while idle.
// The front end takes a beat each cycle while the queue has room, through
// a two-stage multiply pipeline into a two-entry queue. The back end
// handles one sample at a time: a pop, normalization, square root, a setup
// step, division (two bits per cycle) and a result step; a below-threshold
// goes from the pop straight to the result step. The back end takes no new
// sample from the queue before the result of the last one is loaded.
// Sustained throughput is set by the square-root and divider iterations.
// Reset clears the pipeline, the queue and the output; registers return
// to range 0 and minimum magnitude 2676. When the receiver stalls, the
// output holds, then the queue fills and o_s_tready drops.
// ----------------------------------------------------------------------------
module imu_sample_scale_normalize #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // gyro_x_low, gyro_x_high, gyro_y_low, gyro_y_high, gyro_z_low, gyro_z_high,
    // accel_x_low, accel_x_high, accel_y_low, accel_y_high, accel_z_low, accel_z_high
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // rate_x, rate_y, rate_z, unit_x, unit_y, unit_z
    output logic [191:0] o_m_tdata,
    // below_threshold
    output logic         o_m_tuser
);
    import imu_ssn_pkg::*;

    logic   push;
    logic   push_ready;
    t_item  push_item;
    logic   q_valid;
    logic   pop;
    t_item  q_item;

    imu_ssn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data       (i_s_tdata),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    imu_ssn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_item       (push_item),
        .o_valid      (q_valid),
        .i_pop        (pop),
        .o_item       (q_item)
    );

    imu_ssn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_item  (q_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_below (o_m_tuser)
    );

endmodule

>>> verif/imu_sample_scale_normalize_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU scale/normalize checker
// Watches the input and output streams and the register writes, predicts the
// rates and the unit vector of every accepted sample and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module imu_sample_scale_normalize_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [191:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [191:0] i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending
);
    import imu_ssn_pkg::*;

    typedef struct {
        logic [191:0] data;
        logic         below;
    } t_scaled;

    t_scaled     scaled_q[$];
    logic [1:0]  range_sel;
    logic [15:0] accel_min;
    string       names [6] = '{"rate_x", "rate_y", "rate_z", "unit_x", "unit_y", "unit_z"};

    assign o_pending = scaled_q.size();

    function automatic logic signed [63:0] join16(input logic [15:0] lo, input logic [15:0] hi);
        return 64'(signed'({hi, lo}));
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_scaled scale_sample(input logic [191:0] d);
        t_scaled          o;
        logic signed [63:0] raw;
        logic signed [63:0] acc [3];
        logic [63:0]      k;
        logic [63:0]      mag [3];
        logic [63:0]      sum;
        logic [63:0]      v;
        logic [63:0]      r;
        logic [63:0]      n;
        logic [63:0]      q;
        int               e;
        k = (range_sel == 2'd0) ? 64'd119938113 :
            (range_sel == 2'd1) ? 64'd479752452 : 64'd1919009807;
        o.data = '0;
        for (int i = 0; i < 3; i++) begin
            raw = join16(d[32*i +: 16], d[32*i+16 +: 16]);
            o.data[32*i +: 32] = 32'(((64'(raw * signed'(k))) + 64'h8000_0000) >> 32);
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            acc[i] = join16(d[96+32*i +: 16], d[96+32*i+16 +: 16]);
            mag[i] = acc[i] < 0 ? 64'(-acc[i]) : 64'(acc[i]);
            sum = sum + mag[i] * mag[i];
        end
        if (sum <= 64'(accel_min) * 64'(accel_min)) begin
            o.below = 1'b1;
            return o;
        end
        v = sum;
        e = 0;
        while (v < (64'd1 << 62)) begin
            v = v << 2;
            e++;
        end
        r = root64(v);
        for (int i = 0; i < 3; i++) begin
            n = mag[i] << (30 + e);
            q = (2 * n + r) / (2 * r);
            if (acc[i] < 0) q = -q;
            o.data[96+32*i +: 32] = q[31:0];
        end
        o.below = 1'b0;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch %s: got %h, expected %h", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_scaled want;
        if (!i_rst_n) begin
            range_sel <= 2'd0;
            accel_min <= ACCEL_MIN_RESET;
            scaled_q.delete();
        end else begin
            if (i_cfg_wen) begin
                if (i_cfg_idx == REG_GYRO_RANGE) range_sel <= i_cfg_data[1:0];
                else accel_min <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) scaled_q.push_back(scale_sample(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (scaled_q.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata[31:0], 32'd0);
                end else begin
                    want = scaled_q.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (i_m_tdata[32*i +: 32] !== want.data[32*i +: 32])
                            report_mismatch(names[i], i_m_tdata[32*i +: 32],
                                            want.data[32*i +: 32]);
                    if (i_m_tuser !== want.below)
                        report_mismatch("below_threshold", 32'(i_m_tuser), 32'(want.below));
                end
            end
        end
    end

endmodule

>>> verif/imu_sample_scale_normalize_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU scale/normalize testbench
// Drives directed and random samples through several register settings with
// random idle bursts on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module imu_sample_scale_normalize_test;
    import imu_ssn_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wen;
    logic         i_cfg_idx;
    logic [15:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [191:0] o_m_tdata;
    logic         o_m_tuser;
    int           errors;
    int           pending;
    int           cycles;
    bit           calm;

    localparam int CYCLE_LIMIT = 400000;

    imu_sample_scale_normalize dut (.*);

    imu_sample_scale_normalize_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_wen, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: stall in bursts except in the calm tail
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_axis(input int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 3000) - 1500;
            3: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [191:0] d);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_axes(input logic [31:0] g0, g1, g2, a0, a1, a2);
        send({a2, a1, a0, g2, g1, g0});
    endtask

    task automatic drain_and_write(input logic idx, input logic [15:0] val);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) send({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            else send_axes(pick_axis(mode % 5), pick_axis($urandom_range(0, 4)),
                           pick_axis($urandom_range(2, 4)), pick_axis(mode % 5),
                           pick_axis($urandom_range(0, 4)), pick_axis($urandom_range(2, 4)));
        end
    endtask

    initial begin
        cycles     = 0;
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_wen  = 1'b0;
        i_cfg_idx  = REG_GYRO_RANGE;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero vector, threshold edges
        send_axes(0, 0, 0, 0, 0, 0);
        send_axes(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_axes(1, -1, 32'h0001_0000, 32'h8000_0000, 0, 0);
        send_axes(0, 0, 0, 2676, 0, 0);
        send_axes(0, 0, 0, 2677, 0, 0);
        send_axes(0, 0, 0, 0, -2676, 0);
        send_axes(0, 0, 0, 1, 1, 1);
        send_axes(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send({6{32'hFFFF_FFFF}});
        send({6{32'h5555_AAAA}});
        send({6{32'hAAAA_5555}});
        send_axes(0, 0, 0, 1000, 2000, -2000);
        for (int r = 1; r < 4; r++) begin
            drain_and_write(REG_GYRO_RANGE, 16'(r));
            send_axes(32'h7FFF_FFFF, 32'h8000_0000, 12345, 3000, -4000, 0);
        end
        drain_and_write(REG_ACCEL_MIN, 16'hFFFF);
        send_axes(7, 7, 7, 65535, 0, 0);
        send_axes(7, 7, 7, 0, 0, 65536);
        drain_and_write(REG_ACCEL_MIN, 16'd0);
        send_axes(7, 7, 7, 0, 0, 0);
        send_axes(7, 7, 7, 0, 1, 0);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(REG_GYRO_RANGE, 16'($urandom_range(0, 3)) | (16'($urandom) & 16'hFFFC));
            drain_and_write(REG_ACCEL_MIN, (ph % 3 == 0) ? 16'hFFFF :
                                           (ph % 3 == 1) ? 16'd0 : 16'($urandom_range(0, 3000)));
            if (ph == 5) calm = 1'b1;
            random_phase(105);
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
